// ===== src/dclt_pkg.sv =====
// Shared types and constants for the dual-controller character LCD terminal.
package dclt_pkg;
   localparam int COLS_DEF = 40;
   localparam int COL_W = 6;
   localparam int CSR_IDX_W = 3;
   localparam int TDATA_W = 72;

   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DON = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DCUR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SL = 3'd4;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_LO = 8'h20;
   localparam logic [7:0] CH_HI = 8'h7F;
   localparam logic [7:0] SET_ADDR = 8'h80;

   typedef enum logic [2:0] {
      OP_NONE, OP_CLEAR, OP_RET, OP_NL, OP_PRINT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
   } q_item_type;
endpackage

// ===== src/dclt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dclt_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 160
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

// ===== src/dclt_front.sv =====
// Front end: accepts input items, classifies them and queues the operations.
module dclt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tuser,
   output logic                 q_valid,
   output dclt_pkg::q_item_type q_item,
   input  logic                 q_pop
);
   import dclt_pkg::*;

   q_item_type entry_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   op_type     op;
   logic       push;

   always_comb begin
      if (req_tuser) begin
         op = OP_CLEAR;
      end else if (req_tdata == CH_CR) begin
         op = OP_RET;
      end else if (req_tdata == CH_LF) begin
         op = OP_NL;
      end else if (req_tdata inside {[CH_LO : CH_HI - 8'd1]}) begin
         op = OP_PRINT;
      end else begin
         op = OP_NONE;
      end
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready && (op != OP_NONE);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = entry_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= '{op: op, ch: req_tdata};
      end
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== src/dclt_back.sv =====
// Back end: cursor, text shadow, command sequencer, redraw scan and output register.
module dclt_back #(
   parameter int COLS = dclt_pkg::COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  dclt_pkg::q_item_type           q_item,
   output logic                           q_pop,
   input  logic                           csr_we,
   input  logic [dclt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [dclt_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic                           rsp_tlast
);
   import dclt_pkg::*;

   localparam int DEPTH = 4 * COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_CMD = 4'b0010, ST_RD = 4'b0100, ST_PK = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      SQ_CLEAR, SQ_RET, SQ_PRINT, SQ_ROW1, SQ_ROW2, SQ_ROW3, SQ_SCROLL, SQ_SL0, SQ_SL1
   } seq_type;

   logic [7:0] clr_ff, home_ff, don_ff, dcur_ff, sl_ff;

   state_type  state_ff, state_in;
   seq_type    seq_ff, seq_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] row_ff, row_in, base_ff, base_in;
   logic [COL_W-1:0] col_ff, col_in, scol_ff, scol_in;
   logic [1:0] srow_ff, srow_in;
   logic       chg_ff, chg_in, ctl_ff, ctl_in;
   logic [7:0] ch_ff, ch_in;
   logic [2:0] nr_ff, nr_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [ADDR_W-1:0] vidx_ff, vidx_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;

   logic        ov_ff, ov_in, oc_ff, oc_in, od_ff, od_in, ol_ff, ol_in;
   logic [3:0]  on_ff, on_in;
   logic [63:0] opay_ff, opay_in;

   logic        out_free;
   logic        b_ctl, b_end, b_final;
   logic [7:0]  b_cmd;
   logic        ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [6:0]  ram_rdata;
   logic        clr_row_en;
   logic [1:0]  clr_row;
   logic [7:0]  pk_ch;
   logic [63:0] pk_acc;
   logic [3:0]  pk_cnt;
   logic        pk_emit, pk_lastcol;
   logic [2:0]  nr_tmp;

   function automatic seq_type row_seq(input logic [2:0] r);
      case (r)
         3'd1: row_seq = SQ_ROW1;
         3'd2: row_seq = SQ_ROW2;
         3'd3: row_seq = SQ_ROW3;
         default: row_seq = SQ_SCROLL;
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] prow,
                                                  input logic [COL_W-1:0] c);
      addr_of = ADDR_W'(prow * COLS) + ADDR_W'(c);
   endfunction

   dclt_ram #(.WIDTH(7), .DEPTH(DEPTH)) u_shadow (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (q_item.ch[6:0]),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free = !ov_ff || rsp_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tlast = ol_ff;
   assign rsp_tdata = {2'b00, opay_ff, on_ff, od_ff, oc_ff};

   // command beat table
   always_comb begin
      b_ctl = 1'b0;
      b_cmd = clr_ff;
      b_end = 1'b1;
      case (seq_ff)
         SQ_CLEAR: begin
            b_ctl = (k_ff >= 3'd3);
            b_end = (k_ff == 3'd5);
            case (k_ff)
               3'd0, 3'd3: b_cmd = clr_ff;
               3'd1, 3'd4: b_cmd = home_ff;
               3'd2: b_cmd = dcur_ff;
               default: b_cmd = don_ff;
            endcase
         end
         SQ_RET: begin
            b_ctl = ctl_ff;
            b_cmd = home_ff;
         end
         SQ_PRINT: begin
            b_ctl = ctl_ff;
            b_cmd = ch_ff;
         end
         SQ_ROW1: b_cmd = sl_ff;
         SQ_ROW2: begin
            b_ctl = (k_ff != 3'd0);
            b_end = (k_ff == 3'd2);
            case (k_ff)
               3'd0: b_cmd = don_ff;
               3'd1: b_cmd = dcur_ff;
               default: b_cmd = SET_ADDR + 8'(col_ff);
            endcase
         end
         SQ_ROW3: begin
            b_ctl = 1'b1;
            b_cmd = sl_ff;
         end
         SQ_SCROLL: begin
            b_ctl = k_ff[0];
            b_end = (k_ff == 3'd3);
            b_cmd = k_ff[1] ? home_ff : clr_ff;
         end
         SQ_SL0: b_cmd = sl_ff;
         SQ_SL1: begin
            b_ctl = 1'b1;
            b_cmd = sl_ff;
         end
         default: ;
      endcase
      b_final = !((seq_ff == SQ_PRINT) && chg_ff) && (seq_ff != SQ_SCROLL)
                && (seq_ff != SQ_SL0);
   end

   // redraw packing
   always_comb begin
      pk_ch = valid_ff[vidx_ff] ? {1'b0, ram_rdata} : 8'd0;
      pk_acc = acc_ff | ({56'd0, pk_ch} << {cnt_ff[2:0], 3'b000});
      pk_cnt = cnt_ff + {3'd0, (pk_ch != 8'd0)};
      pk_lastcol = (scol_ff == COL_W'(COLS - 1));
      pk_emit = (pk_cnt == 4'd8) || (pk_lastcol && pk_cnt != 4'd0);
   end

   always_comb begin
      state_in = state_ff;
      seq_in = seq_ff;
      k_in = k_ff;
      row_in = row_ff;
      col_in = col_ff;
      base_in = base_ff;
      chg_in = chg_ff;
      ctl_in = ctl_ff;
      ch_in = ch_ff;
      nr_in = nr_ff;
      srow_in = srow_ff;
      scol_in = scol_ff;
      vidx_in = vidx_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      valid_in = valid_ff;
      ov_in = ov_ff && !rsp_tready;
      oc_in = oc_ff;
      od_in = od_ff;
      on_in = on_ff;
      opay_in = opay_ff;
      ol_in = ol_ff;
      q_pop = 1'b0;
      ram_we = 1'b0;
      ram_waddr = addr_of(row_ff + base_ff, col_ff);
      ram_re = 1'b0;
      ram_raddr = addr_of(srow_ff + base_ff, scol_ff);
      clr_row_en = 1'b0;
      clr_row = base_ff;
      nr_tmp = {1'b0, row_ff} + 3'd1;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               state_in = ST_CMD;
               k_in = 3'd0;
               ctl_in = row_ff[1];
               ch_in = q_item.ch;
               case (q_item.op)
                  OP_CLEAR: begin
                     seq_in = SQ_CLEAR;
                     row_in = 2'd0;
                     col_in = '0;
                     valid_in = '0;
                  end
                  OP_RET: begin
                     seq_in = SQ_RET;
                     col_in = '0;
                  end
                  OP_PRINT: begin
                     seq_in = SQ_PRINT;
                     ram_we = 1'b1;
                     valid_in[ram_waddr] = 1'b1;
                     if (col_ff == COL_W'(COLS - 1)) begin
                        col_in = '0;
                        chg_in = 1'b1;
                        nr_in = nr_tmp;
                        row_in = nr_tmp[1:0];
                        if (nr_tmp == 3'd4) begin
                           row_in = 2'd3;
                           base_in = base_ff + 2'd1;
                           clr_row_en = 1'b1;
                        end
                     end else begin
                        col_in = col_ff + COL_W'(1);
                        chg_in = 1'b0;
                     end
                  end
                  default: begin
                     seq_in = row_seq(nr_tmp);
                     row_in = nr_tmp[1:0];
                     if (nr_tmp == 3'd4) begin
                        row_in = 2'd3;
                        col_in = '0;
                        base_in = base_ff + 2'd1;
                        clr_row_en = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_CMD: begin
            if (out_free) begin
               ov_in = 1'b1;
               oc_in = b_ctl;
               od_in = (seq_ff == SQ_PRINT);
               on_in = 4'd1;
               opay_in = {56'd0, b_cmd};
               ol_in = b_end && b_final;
               k_in = k_ff + 3'd1;
               if (b_end) begin
                  k_in = 3'd0;
                  scol_in = '0;
                  acc_in = '0;
                  cnt_in = '0;
                  case (seq_ff)
                     SQ_PRINT: begin
                        if (chg_ff) begin
                           seq_in = row_seq(nr_ff);
                        end else begin
                           state_in = ST_IDLE;
                        end
                     end
                     SQ_SCROLL: begin
                        state_in = ST_RD;
                        srow_in = 2'd0;
                     end
                     SQ_SL0: begin
                        state_in = ST_RD;
                        srow_in = 2'd1;
                     end
                     default: state_in = ST_IDLE;
                  endcase
               end
            end
         end
         ST_RD: begin
            ram_re = 1'b1;
            vidx_in = ram_raddr;
            state_in = ST_PK;
         end
         ST_PK: begin
            if (!pk_emit || out_free) begin
               if (pk_emit) begin
                  ov_in = 1'b1;
                  oc_in = srow_ff[1];
                  od_in = 1'b1;
                  on_in = pk_cnt;
                  opay_in = pk_acc;
                  ol_in = 1'b0;
                  acc_in = '0;
                  cnt_in = '0;
               end else begin
                  acc_in = pk_acc;
                  cnt_in = pk_cnt;
               end
               if (pk_lastcol) begin
                  scol_in = '0;
                  case (srow_ff)
                     2'd0: begin
                        state_in = ST_CMD;
                        seq_in = SQ_SL0;
                     end
                     2'd1: begin
                        state_in = ST_RD;
                        srow_in = 2'd2;
                     end
                     default: begin
                        state_in = ST_CMD;
                        seq_in = SQ_SL1;
                     end
                  endcase
               end else begin
                  scol_in = scol_ff + COL_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < COLS; c++) begin
            if (clr_row_en && clr_row == 2'(r)) begin
               valid_in[r * COLS + c] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      k_ff <= k_in;
      chg_ff <= chg_in;
      ctl_ff <= ctl_in;
      ch_ff <= ch_in;
      nr_ff <= nr_in;
      srow_ff <= srow_in;
      scol_ff <= scol_in;
      vidx_ff <= vidx_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      oc_ff <= oc_in;
      od_ff <= od_in;
      on_ff <= on_in;
      opay_ff <= opay_in;
      ol_ff <= ol_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff <= 2'd0;
         col_ff <= '0;
         base_ff <= 2'd0;
         valid_ff <= '0;
         ov_ff <= 1'b0;
         clr_ff <= 8'h01;
         home_ff <= 8'h02;
         don_ff <= 8'h0C;
         dcur_ff <= 8'h0F;
         sl_ff <= 8'hA8;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         col_ff <= col_in;
         base_ff <= base_in;
         valid_ff <= valid_in;
         ov_ff <= ov_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CLEAR: clr_ff <= csr_wdata;
               CSR_HOME: home_ff <= csr_wdata;
               CSR_DON: don_ff <= csr_wdata;
               CSR_DCUR: dcur_ff <= csr_wdata;
               CSR_SL: sl_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

// ===== src/dual_controller_char_lcd_terminal.sv =====
// Character stream to write beats for a 40x4 LCD driven by two controllers.
// An item is popped in the idle state; its command beats are issued from the command state
// through the output register, and the next item is not popped until all of them are issued.
// A scroll redraws three rows through the shadow RAM read port, each cell passing through a
// read state and a pack state; output back-pressure can stall the redraw.
// Reset: cursor at row 0 column 0, shadow empty, registers at defaults, queue empty.
module dual_controller_char_lcd_terminal #(
   parameter int COLS = dclt_pkg::COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // char_code
   input  logic                           req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // controller, is_data, byte_count[3:0], payload[63:0], pad
   output logic [dclt_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [dclt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);
   import dclt_pkg::*;

   logic       q_valid, q_pop;
   q_item_type q_item;

   dclt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   dclt_back #(.COLS(COLS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
